>>> hdl/ipv4p_pkg.sv
// shared constants for the dotted-decimal ipv4 parser
package ipv4p_pkg;

    localparam int CHAR_W    = 8;
    localparam int PART_W    = 9;
    localparam int DOTS_W    = 2;
    localparam int ADDR_W    = 32;
    localparam int PROD_W    = 13;

    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2e;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    localparam logic [PART_W-1:0] PART_MAX  = 9'd511;
    localparam logic [PART_W-1:0] OCTET_MAX = 9'd255;
    localparam logic [DOTS_W-1:0] DOTS_MAX  = 2'd3;

endpackage

>>> hdl/ipv4_dotted_decimal_parser.sv
// dotted-decimal ipv4 address parser, one ascii character per request
//
// input channel (s_*): one character per request in s_tdata; a zero byte
// ends the string. non-terminating characters produce no result.
// output channel (m_*): one result per terminating zero: m_tuser[0] is the
// valid flag, m_tdata the address with the first octet in bits 31:24
// (zero when the string is invalid).
// the result shows on m_tvalid once the accepted zero byte has passed the
// input register, then the result register.
// throughput: one character per cycle while s_tready is high, each accepted
// character updating the part accumulator (multiply by ten, add, saturate) and address shift.
// when the receiver stalls, the result register holds its request and
// characters still flow in until a second zero byte reaches the input
// register; then s_tready drops until the pending result is taken.
// reset clears the parser state, the input register and the result valid
// flag (not the result data); no result is pending after reset.
module ipv4_dotted_decimal_parser
    import ipv4p_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] character
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] address
    output logic [0:0]        m_tuser    // [0] valid_res
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;

    logic [PART_W-1:0] part_reg, part_next;
    logic [DOTS_W-1:0] dots_reg, dots_next;
    logic [ADDR_W-1:0] partial_reg, partial_next;
    logic              error_reg, error_next;

    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [ADDR_W-1:0] out_addr_reg;

    logic              is_nul;
    logic              is_dot;
    logic              is_digit;
    logic              advance;
    logic              part_ok;
    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] pushed;
    logic [ADDR_W-1:0] aligned;
    logic              res_ok;
    logic [ADDR_W-1:0] res_addr;

    assign is_nul   = (in_char_reg == CHAR_NUL);
    assign is_dot   = (in_char_reg == CHAR_DOT);
    assign is_digit = (in_char_reg >= CHAR_ZERO) && (in_char_reg <= CHAR_NINE);

    // only a terminating character needs room in the result register
    assign advance  = in_valid_reg && (!is_nul || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign part_ok = (part_reg <= OCTET_MAX);
    assign prod    = PROD_W'(part_reg) * PROD_W'(10)
                   + PROD_W'(in_char_reg[3:0] - CHAR_ZERO[3:0]);
    assign pushed  = {partial_reg[ADDR_W-9:0], part_reg[7:0]};

    always_comb
    begin
        case (dots_reg)
            2'd0:    aligned = {pushed[7:0], 24'd0};
            2'd1:    aligned = {pushed[15:0], 16'd0};
            2'd2:    aligned = {pushed[23:0], 8'd0};
            default: aligned = pushed;
        endcase
    end

    assign res_ok   = !error_reg && part_ok;
    assign res_addr = res_ok ? aligned : '0;

    always_comb
    begin
        part_next    = part_reg;
        dots_next    = dots_reg;
        partial_next = partial_reg;
        error_next   = error_reg;
        if (is_nul)
        begin
            part_next    = '0;
            dots_next    = '0;
            partial_next = '0;
            error_next   = 1'b0;
        end
        else if (!error_reg)
        begin
            if (is_digit)
            begin
                part_next = (prod > PROD_W'(PART_MAX)) ? PART_MAX : prod[PART_W-1:0];
            end
            else if (is_dot)
            begin
                if ((dots_reg == DOTS_MAX) || !part_ok)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    partial_next = pushed;
                    part_next    = '0;
                    dots_next    = dots_reg + 2'd1;
                end
            end
            else
            begin
                error_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_char_reg   <= '0;
            part_reg      <= '0;
            dots_reg      <= '0;
            partial_reg   <= '0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                in_char_reg  <= s_tdata;
            end
            if (advance)
            begin
                part_reg    <= part_next;
                dots_reg    <= dots_next;
                partial_reg <= partial_next;
                error_reg   <= error_next;
            end
            if (advance && is_nul)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_nul)
        begin
            out_ok_reg   <= res_ok;
            out_addr_reg <= res_addr;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_ok_reg;

endmodule

>>> hdl/ipv4p_checker.sv
// port-level checks for the dotted-decimal ipv4 parser, bound to the top level
module ipv4p_checker
    import ipv4p_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [7:0]        s_tdata,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [31:0]       m_tdata,
    input logic [0:0]        m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an invalid string reports a zero address
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid result with nonzero address");

    // a fresh result traces back to an accepted terminating character
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tdata == CHAR_NUL), 2))
        else $error("result without terminating character");

    // input backpressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind ipv4_dotted_decimal_parser ipv4p_checker u_ipv4p_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
